/* rtl/spectrum_amplitude_phase_mixer_macros.svh */
// Assertion macros for the amplitude/phase mixer.
`ifndef SPECTRUM_AMPLITUDE_PHASE_MIXER_MACROS_SVH
`define SPECTRUM_AMPLITUDE_PHASE_MIXER_MACROS_SVH

// Same-cycle implication.
`define SAPM_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mixer assertion failed (same cycle)");

// Next-cycle implication.
`define SAPM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mixer assertion failed (next cycle)");

`endif

/* rtl/sapm_pkg.sv */
// Shared types and constants for the amplitude/phase mixer.
package sapm_pkg;

  localparam int FRAC_BITS = 16;
  localparam int SQ_STEPS  = 32;
  localparam int DIV_STEPS = 32;

  typedef enum logic [1:0] {
    MIX_UNIT    = 2'd0,
    MIX_B_PHASE = 2'd1,
    MIX_A_PHASE = 2'd2,
    MIX_SPLIT   = 2'd3
  } mode_t;

  // carried alongside the square-root pipeline
  typedef struct packed {
    mode_t       mode;
    logic [31:0] ra;
    logic [31:0] ia;
    logic [31:0] rb;
    logic [31:0] ib;
    logic        nra;
    logic        nia;
    logic        nrb;
    logic        nib;
  } sqrt_side_t;

  // carried alongside the divider pipeline
  typedef struct packed {
    mode_t       mode;
    logic        nr;
    logic        ni;
    logic        zdiv;
    logic [31:0] half;
  } div_side_t;

endpackage

/* rtl/spectrum_amplitude_phase_mixer.sv */
// Throughput: one transaction per cycle while in_stall is low, set by
// the fully pipelined 32-stage square root and 32-stage divider (one
// bit per stage), between the input stages and the output register.
// Reset (rst, synchronous, active high) empties the pipeline and the
// output/skid registers and sets mix_mode to unit magnitude.
// Configuration writes are always ready.
`include "spectrum_amplitude_phase_mixer_macros.svh"
module spectrum_amplitude_phase_mixer
  import sapm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] re_a,
  input  logic [31:0] im_a,
  input  logic [31:0] re_b,
  input  logic [31:0] im_b,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] re_out,
  output logic [31:0] im_out,
  output logic        zero_divisor,
  output logic        clipped
);

  // ---------------------------------------------------------------------
  // Mode register
  // ---------------------------------------------------------------------
  mode_t mix_mode;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mix_mode <= MIX_UNIT;
    end else if (cfg_valid && cfg_ready) begin
      mix_mode <= mode_t'(cfg_data);
    end
  end

  // ---------------------------------------------------------------------
  // Flow control: the whole pipeline moves together unless the skid
  // register is occupied. The skid catches the one item that leaves the
  // pipeline in the cycle the output stalls, so in_stall is a register.
  // ---------------------------------------------------------------------
  logic skid_v;
  logic en;
  assign en       = !skid_v;
  assign in_stall = skid_v;

  function automatic logic [31:0] mag32(input logic [31:0] x);
    return x[31] ? (~x + 32'd1) : x;
  endfunction

  // Stage 0: sign/magnitude split
  logic       v0;
  sqrt_side_t s0;

  always_ff @(posedge clk) begin
    if (rst) v0 <= 1'b0;
    else if (en) v0 <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0.mode <= mix_mode;
      s0.ra   <= mag32(re_a);
      s0.ia   <= mag32(im_a);
      s0.rb   <= mag32(re_b);
      s0.ib   <= mag32(im_b);
      s0.nra  <= re_a[31];
      s0.nia  <= im_a[31];
      s0.nrb  <= re_b[31];
      s0.nib  <= im_b[31];
    end
  end

  // Stage 1: squares
  logic        v1;
  sqrt_side_t  s1;
  logic [63:0] sq_ra, sq_ia, sq_rb, sq_ib;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= v0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1    <= s0;
      sq_ra <= 64'(s0.ra) * 64'(s0.ra);
      sq_ia <= 64'(s0.ia) * 64'(s0.ia);
      sq_rb <= 64'(s0.rb) * 64'(s0.rb);
      sq_ib <= 64'(s0.ib) * 64'(s0.ib);
    end
  end

  // Stage 2: sums; split mode takes the root of half of |A|^2
  logic        v2;
  sqrt_side_t  s2;
  logic [63:0] rad_x, rad_y;
  logic [63:0] sum_a;
  assign sum_a = sq_ra + sq_ia;

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2    <= s1;
      rad_x <= (s1.mode == MIX_SPLIT) ? (sum_a >> 1) : sum_a;
      rad_y <= sq_rb + sq_ib;
    end
  end

  // Square roots
  logic        v3;
  logic [31:0] ma, mb;
  sqrt_side_t  s3;

  sapm_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_v     (v2),
    .rad_x    (rad_x),
    .rad_y    (rad_y),
    .in_side  (s2),
    .out_v    (v3),
    .root_x   (ma),
    .root_y   (mb),
    .out_side (s3)
  );

  // Stage P: numerator products, divisor select
  logic        v4;
  logic [63:0] prod_r, prod_i;
  logic [31:0] den4;
  div_side_t   d4;
  logic [31:0] op_r, op_i, op_m, den_sel;
  logic        b_path;

  always_comb begin
    b_path  = (s3.mode == MIX_B_PHASE);
    op_r    = b_path ? s3.rb : s3.ra;
    op_i    = b_path ? s3.ib : s3.ia;
    op_m    = b_path ? ma : mb;
    den_sel = b_path ? mb : ma;
  end

  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (en) v4 <= v3;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (s3.mode == MIX_UNIT) begin
        prod_r <= 64'(s3.ra) << FRAC_BITS;
        prod_i <= 64'(s3.ia) << FRAC_BITS;
      end else begin
        prod_r <= 64'(op_r) * 64'(op_m);
        prod_i <= 64'(op_i) * 64'(op_m);
      end
      den4    <= den_sel;
      d4.mode <= s3.mode;
      d4.nr   <= b_path ? s3.nrb : s3.nra;
      d4.ni   <= b_path ? s3.nib : s3.nia;
      d4.zdiv <= (s3.mode != MIX_SPLIT) && (den_sel == 32'd0);
      d4.half <= ma;
    end
  end

  // Stage Q: add half divisor for round half away from zero
  logic        v5;
  logic [63:0] num_r, num_i;
  logic [31:0] den5;
  div_side_t   d5;

  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else if (en) v5 <= v4;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_r <= prod_r + 64'(den4 >> 1);
      num_i <= prod_i + 64'(den4 >> 1);
      den5  <= den4;
      d5    <= d4;
    end
  end

  // Division
  logic        v6;
  logic [31:0] q_r, q_i;
  div_side_t   d6;

  sapm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_v     (v5),
    .num_r    (num_r),
    .num_i    (num_i),
    .den      (den5),
    .in_side  (d5),
    .out_v    (v6),
    .quo_r    (q_r),
    .quo_i    (q_i),
    .out_side (d6)
  );

  // Final: sign, saturation, special cases
  function automatic logic [32:0] sat_apply(input logic [31:0] q, input logic neg);
    logic        clip;
    logic [31:0] m;
    if (neg) begin
      clip = (q > 32'h8000_0000);
      m    = clip ? 32'h8000_0000 : q;
      return {clip, ~m + 32'd1};
    end
    clip = q[31];
    return {clip, clip ? 32'h7FFF_FFFF : q};
  endfunction

  logic        fin_v;
  logic [31:0] fin_re, fin_im;
  logic        fin_zd, fin_cl;
  logic [32:0] sr, si;

  always_comb begin
    fin_v  = v6 && en;
    sr     = sat_apply(q_r, d6.nr);
    si     = sat_apply(q_i, d6.ni);
    fin_re = '0;
    fin_im = '0;
    fin_zd = 1'b0;
    fin_cl = 1'b0;
    if (d6.mode == MIX_SPLIT) begin
      sr     = sat_apply(d6.half, 1'b0);
      fin_re = sr[31:0];
      fin_im = sr[31:0];
      fin_cl = sr[32];
    end else if (d6.zdiv) begin
      fin_zd = 1'b1;
    end else begin
      fin_re = sr[31:0];
      fin_im = si[31:0];
      fin_cl = sr[32] | si[32];
    end
  end

  // Output register and skid
  logic [31:0] sk_re, sk_im;
  logic        sk_zd, sk_cl;
  logic        out_free;
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_v    <= 1'b0;
    end else if (out_free) begin
      if (skid_v) begin
        out_valid <= 1'b1;
        skid_v    <= 1'b0;
      end else begin
        out_valid <= fin_v;
      end
    end else if (fin_v) begin
      skid_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_v) begin
        re_out       <= sk_re;
        im_out       <= sk_im;
        zero_divisor <= sk_zd;
        clipped      <= sk_cl;
      end else begin
        re_out       <= fin_re;
        im_out       <= fin_im;
        zero_divisor <= fin_zd;
        clipped      <= fin_cl;
      end
    end else if (fin_v) begin
      sk_re <= fin_re;
      sk_im <= fin_im;
      sk_zd <= fin_zd;
      sk_cl <= fin_cl;
    end
  end

  // Assertions
  `SAPM_ASSERT_NOW(a_skid_implies_out, clk, rst, skid_v, out_valid)
  `SAPM_ASSERT_NEXT(a_skid_drains, clk, rst, skid_v && !out_stall, !skid_v)
  `SAPM_ASSERT_NOW(a_zdiv_zero, clk, rst, out_valid && zero_divisor, ~|{re_out, im_out, clipped})

endmodule

/* rtl/sapm_isqrt.sv */
// Two-lane pipelined integer square root, one root bit per stage.
module sapm_isqrt
  import sapm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_v,
  input  logic [63:0] rad_x,
  input  logic [63:0] rad_y,
  input  sqrt_side_t  in_side,
  output logic        out_v,
  output logic [31:0] root_x,
  output logic [31:0] root_y,
  output sqrt_side_t  out_side
);

  typedef struct packed {
    logic [63:0] rad;
    logic [33:0] rem;
    logic [31:0] root;
  } sq_lane_t;

  function automatic sq_lane_t sq_step(input sq_lane_t l);
    logic [35:0] t;
    logic [35:0] trial;
    sq_lane_t    o;
    t       = {l.rem, l.rad[63:62]};
    trial   = {2'b00, l.root, 2'b01};
    o.rad   = {l.rad[61:0], 2'b00};
    if (t >= trial) begin
      o.rem  = 34'(t - trial);
      o.root = {l.root[30:0], 1'b1};
    end else begin
      o.rem  = t[33:0];
      o.root = {l.root[30:0], 1'b0};
    end
    return o;
  endfunction

  logic       v    [SQ_STEPS];
  sq_lane_t   lx   [SQ_STEPS];
  sq_lane_t   ly   [SQ_STEPS];
  sqrt_side_t side [SQ_STEPS];

  sq_lane_t seed_x, seed_y;
  assign seed_x = '{rad: rad_x, rem: '0, root: '0};
  assign seed_y = '{rad: rad_y, rem: '0, root: '0};

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < SQ_STEPS; k++) v[k] <= 1'b0;
    end else if (en) begin
      v[0] <= in_v;
      for (int k = 1; k < SQ_STEPS; k++) v[k] <= v[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lx[0]   <= sq_step(seed_x);
      ly[0]   <= sq_step(seed_y);
      side[0] <= in_side;
      for (int k = 1; k < SQ_STEPS; k++) begin
        lx[k]   <= sq_step(lx[k-1]);
        ly[k]   <= sq_step(ly[k-1]);
        side[k] <= side[k-1];
      end
    end
  end

  assign out_v    = v[SQ_STEPS-1];
  assign root_x   = lx[SQ_STEPS-1].root;
  assign root_y   = ly[SQ_STEPS-1].root;
  assign out_side = side[SQ_STEPS-1];

endmodule

/* rtl/sapm_div.sv */
// Two-lane pipelined restoring divider, one quotient bit per stage.
module sapm_div
  import sapm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_v,
  input  logic [63:0] num_r,
  input  logic [63:0] num_i,
  input  logic [31:0] den,
  input  div_side_t   in_side,
  output logic        out_v,
  output logic [31:0] quo_r,
  output logic [31:0] quo_i,
  output div_side_t   out_side
);

  // acc holds {partial remainder, remaining dividend bits / quotient bits}
  function automatic logic [63:0] div_step(input logic [63:0] acc, input logic [31:0] d);
    logic [32:0] t;
    logic [32:0] r;
    logic        q;
    t = {acc[63:32], acc[31]};
    if (t >= {1'b0, d}) begin
      r = t - {1'b0, d};
      q = 1'b1;
    end else begin
      r = t;
      q = 1'b0;
    end
    return {r[31:0], acc[30:0], q};
  endfunction

  logic        v    [DIV_STEPS];
  logic [63:0] ar   [DIV_STEPS];
  logic [63:0] ai   [DIV_STEPS];
  logic [31:0] dd   [DIV_STEPS];
  div_side_t   side [DIV_STEPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DIV_STEPS; k++) v[k] <= 1'b0;
    end else if (en) begin
      v[0] <= in_v;
      for (int k = 1; k < DIV_STEPS; k++) v[k] <= v[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ar[0]   <= div_step(num_r, den);
      ai[0]   <= div_step(num_i, den);
      dd[0]   <= den;
      side[0] <= in_side;
      for (int k = 1; k < DIV_STEPS; k++) begin
        ar[k]   <= div_step(ar[k-1], dd[k-1]);
        ai[k]   <= div_step(ai[k-1], dd[k-1]);
        dd[k]   <= dd[k-1];
        side[k] <= side[k-1];
      end
    end
  end

  assign out_v    = v[DIV_STEPS-1];
  assign quo_r    = ar[DIV_STEPS-1][31:0];
  assign quo_i    = ai[DIV_STEPS-1][31:0];
  assign out_side = side[DIV_STEPS-1];

endmodule

/* verif/spectrum_amplitude_phase_mixer_tb.sv */
// Self-checking testbench for the amplitude/phase mixer: directed bins per mode, random bins in randomly chosen modes.
`timescale 1ns / 100ps
module spectrum_amplitude_phase_mixer_tb;
  import sapm_pkg::*;

  // Expected output of one bin
  typedef struct {
    logic [31:0] re;
    logic [31:0] im;
    logic        zdiv;
    logic        clip;
  } mix_result_t;

  // Predicts each bin from the current mode and checks results in order
  class mix_scoreboard;
    mode_t       mode;
    mix_result_t pending[$];
    int          errors;

    function new();
      mode = MIX_UNIT;
      errors = 0;
    endfunction

    static function logic [63:0] root64(logic [63:0] v);
      logic [63:0] r;
      logic [63:0] b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    static function logic [63:0] magn(logic [31:0] x);
      return x[31] ? (64'h1_0000_0000 - {32'd0, x}) : {32'd0, x};
    endfunction

    static function logic [31:0] clamp(logic [63:0] m, logic neg, inout logic clip);
      if (neg) begin
        if (m > 64'h8000_0000) begin
          clip = 1'b1;
          m = 64'h8000_0000;
        end
        return 32'(64'h1_0000_0000 - m);
      end
      if (m > 64'h7FFF_FFFF) begin
        clip = 1'b1;
        m = 64'h7FFF_FFFF;
      end
      return m[31:0];
    endfunction

    // note an accepted input transaction
    function void note_bin(logic [31:0] ra_s, logic [31:0] ia_s,
                           logic [31:0] rb_s, logic [31:0] ib_s);
      logic [63:0] ra, ia, rb, ib, sqa, ma, mb, h, nr, ni, k, d;
      logic        sr, si;
      mix_result_t e;
      ra = magn(ra_s); ia = magn(ia_s); rb = magn(rb_s); ib = magn(ib_s);
      sqa = ra * ra + ia * ia;
      ma = root64(sqa);
      mb = root64(rb * rb + ib * ib);
      e.re = 0; e.im = 0; e.zdiv = 0; e.clip = 0;
      nr = ra; ni = ia; sr = ra_s[31]; si = ia_s[31]; k = 0; d = ma;
      case (mode)
        MIX_UNIT:    k = 64'd1 << FRAC_BITS;
        MIX_B_PHASE: begin
          nr = rb; ni = ib; sr = rb_s[31]; si = ib_s[31]; k = ma; d = mb;
        end
        MIX_A_PHASE: k = mb;
        default:     k = 0;
      endcase
      if (mode == MIX_SPLIT) begin
        h = root64(sqa >> 1);
        e.re = clamp(h, 1'b0, e.clip);
        e.im = e.re;
      end else if (d == 0) begin
        e.zdiv = 1'b1;
      end else begin
        e.re = clamp((nr * k + (d >> 1)) / d, sr, e.clip);
        e.im = clamp((ni * k + (d >> 1)) / d, si, e.clip);
      end
      pending.push_back(e);
    endfunction

    // check one accepted output transaction
    function void check_bin(logic [31:0] re, logic [31:0] im, logic zd, logic cl);
      mix_result_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result re=%h im=%h", $time, re, im);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (re !== e.re) begin
        $display("%0t: re_out expected %h actual %h", $time, e.re, re);
        errors++;
      end
      if (im !== e.im) begin
        $display("%0t: im_out expected %h actual %h", $time, e.im, im);
        errors++;
      end
      if (zd !== e.zdiv) begin
        $display("%0t: zero_divisor expected %b actual %b", $time, e.zdiv, zd);
        errors++;
      end
      if (cl !== e.clip) begin
        $display("%0t: clipped expected %b actual %b", $time, e.clip, cl);
        errors++;
      end
    endfunction
  endclass

  localparam int LATENCY   = 69;
  localparam int MAX_CYCLES = 400000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] re_a = '0, im_a = '0, re_b = '0, im_b = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] re_out, im_out;
  logic        zero_divisor, clipped;

  mix_scoreboard sb = new();
  int send_idle_pct = 0;   // chance that the sender holds off a cycle
  int recv_stall_pct = 0;  // chance that the sink stalls a cycle
  int cycles = 0;

  spectrum_amplitude_phase_mixer dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .re_a(re_a), .im_a(im_a), .re_b(re_b), .im_b(im_b),
    .out_valid(out_valid), .out_stall(out_stall),
    .re_out(re_out), .im_out(im_out),
    .zero_divisor(zero_divisor), .clipped(clipped)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYCLES) begin
      $display("Verification failed");
      $finish;
    end
  end

  // output side: sample at rising edge, new stall decision at falling edge
  always @(posedge clk)
    if (!rst && out_valid && !out_stall)
      sb.check_bin(re_out, im_out, zero_divisor, clipped);

  always @(negedge clk)
    out_stall <= ($urandom_range(99) < recv_stall_pct);

  // one input transaction; the payload holds while stalled
  task automatic send_bin(logic [31:0] a_r, logic [31:0] a_i,
                          logic [31:0] b_r, logic [31:0] b_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    re_a <= a_r; im_a <= a_i; re_b <= b_r; im_b <= b_i;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_bin(a_r, a_i, b_r, b_i);
    @(negedge clk);
  endtask

  // wait for the pipe to drain, then write the mode register
  task automatic set_mode(mode_t m);
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= m;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.mode = m;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // random value biased toward extremes and small magnitudes
  function automatic logic [31:0] pick_val();
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'(int'($urandom_range(8)) - 4);
      3: return 32'(int'($urandom_range(1 << 20)) - (1 << 19));
      4: return 32'(int'($urandom_range(1 << 8)) - (1 << 7)) << 16;
      default: return $urandom();
    endcase
  endfunction

  logic [31:0] edge_vals[6] = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                                32'h8000_0000, 32'h0001_0000};

  initial begin
    mode_t modes[4] = '{MIX_UNIT, MIX_B_PHASE, MIX_A_PHASE, MIX_SPLIT};
    int    pcts[4][2] = '{'{0, 0}, '{56, 0}, '{0, 56}, '{32, 32}};
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: extremes, zero divisors, split-mode overflow, in each mode
    foreach (modes[m]) begin
      set_mode(modes[m]);
      send_bin(0, 0, 32'h0001_0000, 0);                 // |A| zero
      send_bin(32'h0001_0000, 0, 0, 0);                 // |B| zero
      send_bin(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_bin(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 0);
      send_bin(1, 0, 32'h7FFF_FFFF, 32'h8000_0000);     // huge gain in A-phase mode, saturates
      send_bin(32'hFFFF_FFFF, 1, 32'hFFFF_0000, 32'h0003_0000);
    end

    // random phases: a randomly chosen mode per phase, cycling through the idling patterns
    for (int p = 0; p < 16; p++) begin
      set_mode(modes[$urandom_range(3)]);
      send_idle_pct = pcts[p % 4][0];
      recv_stall_pct = pcts[p % 4][1];
      for (int i = 0; i < 38; i++)
        send_bin(pick_val(), pick_val(), pick_val(), pick_val());
      for (int i = 0; i < 6 && p == 0; i++)
        send_bin(edge_vals[i], edge_vals[5 - i], edge_vals[i], edge_vals[i]);
    end
    in_valid <= 1'b0;
    recv_stall_pct = 0;

    while (sb.pending.size() != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
